FILE: sv/wufr_pkg.sv
// shared types and constants of the weighted union-find ratio store
// no dependencies; imported by the top level and wufr_arith

package wufr_pkg;

   localparam int NODES  = 256;
   localparam int NODE_W = $clog2(NODES);
   localparam int LEN_W  = NODE_W + 1;
   localparam int Q_W    = 48;
   localparam int PROD_W = 2 * Q_W;
   localparam int NODE_RAM_W = NODE_W + Q_W;

   localparam logic [Q_W-1:0] Q_ONE = 48'h0001_0000_0000;
   localparam logic [Q_W-1:0] Q_MAX = 48'hFFFF_FFFF_FFFF;

   localparam logic ACT_UNION = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic             action;
      logic [7:0]       node_a;
      logic [7:0]       node_b;
      logic [Q_W-1:0]   ratio;
   } req_type;

   typedef struct packed {
      logic             connected;
      logic [Q_W-1:0]   ratio_result;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_POP,
      ST_POP_WAIT,
      ST_RD_M,
      ST_RD_P,
      ST_CMP_MUL,
      ST_FIND_DONE,
      ST_LK_B,
      ST_LK_A,
      ST_LK_MUL,
      ST_LK_DIV,
      ST_Q_A,
      ST_Q_B,
      ST_Q_DIV,
      ST_RESP
   } state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic              start;
      arith_op_type      op;
      logic [PROD_W-1:0] num;
      logic [Q_W-1:0]    den;
   } arith_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
      logic [Q_W-1:0]    quotient;
   } arith_rsp_type;

endpackage

FILE: sv/weighted_union_find_ratio.sv
// top level of the weighted union-find ratio store
// depends on wufr_pkg, wufr_ram (node and path stack) and wufr_arith
//
//  channel | ports                          | moves
//  --------+--------------------------------+--------------------------------
//  request | req_valid req_stall req_data   | union or query transaction
//  result  | rsp_valid rsp_stall rsp_data   | one per query transaction
//
// one transaction at a time; a find reads and checks each parent on the way up,
// pushing each node onto the path stack, then pops and rewrites each node with
// its weight times its parent's from the multiplier; a union link adds a
// multiply then a 96-step divide, a query one divide for its ratio
// reset clears the seen flip-flops but no ram entry; a node's ram entry gets its reset
// value when a union first marks the node seen, so no clearing pass is needed
// req_stall is high whenever a transaction is in progress; a pending result
// does not block the next request until that request's own result is ready

module weighted_union_find_ratio
   import wufr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic              phase_ff, phase_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [NODE_W-1:0] root_ff, root_in;
   logic [NODE_W-1:0] root_a_ff, root_a_in;
   logic [NODE_W-1:0] m_ff, m_in;
   logic [Q_W-1:0]    wtmp_ff, wtmp_in;
   logic              res_conn_ff, res_conn_in;
   logic [Q_W-1:0]    res_ratio_ff, res_ratio_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [NODES-1:0]  seen_ff, seen_in;
   logic              b_init_ff, b_init_in;

   logic                  node_wr_en, node_rd_en;
   logic [NODE_W-1:0]     node_wr_addr, node_rd_addr;
   logic [NODE_RAM_W-1:0] node_wr_data, node_q;
   logic                  stk_wr_en, stk_rd_en;
   logic [NODE_W-1:0]     stk_wr_addr, stk_rd_addr, stk_q;

   arith_cmd_type     arith_cmd;
   arith_rsp_type     arith_rsp;

   logic              accept;
   logic [NODE_W-1:0] rd_parent;
   logic [Q_W-1:0]    rd_weight;
   logic [Q_W-1:0]    qmul;
   logic [LEN_W-1:0]  len_dec;
   logic              rsp_free;

   wufr_ram #(.WIDTH(NODE_RAM_W), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_q)
   );

   wufr_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (cur_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_q)
   );

   wufr_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign len_dec   = len_ff - LEN_W'(1);

   // only seen nodes and their ancestors are ever read
   assign rd_parent = node_q[NODE_RAM_W-1:Q_W];
   assign rd_weight = node_q[Q_W-1:0];
   assign qmul = (arith_rsp.product[PROD_W-1:PROD_W-16] != '0) ? Q_MAX
                 : arith_rsp.product[PROD_W-17:32];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_UNION) begin
                  state_in = ST_WALK_RD;
               end else if (seen_ff[req_data.node_a] && seen_ff[req_data.node_b]) begin
                  state_in = ST_WALK_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_WALK_RD:  state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            if (rd_parent != cur_ff) begin
               state_in = ST_WALK_RD;
            end else if (len_ff == '0) begin
               state_in = ST_FIND_DONE;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP:      state_in = ST_POP_WAIT;
         ST_POP_WAIT: state_in = ST_RD_M;
         ST_RD_M:     state_in = ST_RD_P;
         ST_RD_P:     state_in = ST_CMP_MUL;
         ST_CMP_MUL: begin
            if (arith_rsp.done) begin
               state_in = (len_ff == '0) ? ST_FIND_DONE : ST_POP;
            end
         end
         ST_FIND_DONE: begin
            if (!phase_ff) begin
               state_in = ST_WALK_RD;
            end else if (req_ff.action == ACT_UNION) begin
               state_in = (root_a_ff == root_ff) ? ST_IDLE : ST_LK_B;
            end else begin
               state_in = (root_a_ff == root_ff) ? ST_Q_A : ST_RESP;
            end
         end
         ST_LK_B:   state_in = ST_LK_A;
         ST_LK_A:   state_in = ST_LK_MUL;
         ST_LK_MUL: if (arith_rsp.done) state_in = ST_LK_DIV;
         ST_LK_DIV: if (arith_rsp.done) state_in = ST_IDLE;
         ST_Q_A:    state_in = ST_Q_B;
         ST_Q_B:    state_in = ST_Q_DIV;
         ST_Q_DIV:  if (arith_rsp.done) state_in = ST_RESP;
         ST_RESP:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      req_in       = req_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      root_in      = root_ff;
      root_a_in    = root_a_ff;
      m_in         = m_ff;
      wtmp_in      = wtmp_ff;
      res_conn_in  = res_conn_ff;
      res_ratio_in = res_ratio_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      seen_in      = seen_ff;
      b_init_in    = b_init_ff;
      node_wr_en   = 1'b0;
      node_wr_addr = m_ff;
      node_wr_data = '0;
      node_rd_en   = 1'b0;
      node_rd_addr = cur_ff;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = len_ff[NODE_W-1:0];
      stk_rd_en    = 1'b0;
      stk_rd_addr  = len_dec[NODE_W-1:0];
      arith_cmd.start = 1'b0;
      arith_cmd.op    = OP_MUL;
      arith_cmd.num   = {{(PROD_W-Q_W){1'b0}}, wtmp_ff};
      arith_cmd.den   = wtmp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               phase_in     = 1'b0;
               cur_in       = req_data.node_a;
               len_in       = '0;
               res_conn_in  = 1'b0;
               res_ratio_in = '0;
               b_init_in    = 1'b0;
               if (req_data.action == ACT_UNION) begin
                  seen_in[req_data.node_a] = 1'b1;
                  seen_in[req_data.node_b] = 1'b1;
                  // first sighting: give the entry its reset value
                  if (!seen_ff[req_data.node_a]) begin
                     node_wr_en   = 1'b1;
                     node_wr_addr = req_data.node_a;
                     node_wr_data = {req_data.node_a, Q_ONE};
                  end
                  b_init_in = !seen_ff[req_data.node_b] &&
                              (req_data.node_b != req_data.node_a);
               end
            end
         end
         ST_WALK_RD: begin
            node_rd_en   = 1'b1;
            node_rd_addr = cur_ff;
            if (b_init_ff) begin
               node_wr_en   = 1'b1;
               node_wr_addr = req_ff.node_b;
               node_wr_data = {req_ff.node_b, Q_ONE};
               b_init_in    = 1'b0;
            end
         end
         ST_WALK_CHK: begin
            if (rd_parent != cur_ff) begin
               stk_wr_en = 1'b1;
               len_in    = len_ff + LEN_W'(1);
               cur_in    = rd_parent;
            end else begin
               root_in = cur_ff;
            end
         end
         ST_POP: begin
            stk_rd_en = 1'b1;
            len_in    = len_dec;
         end
         ST_POP_WAIT: begin
            m_in         = stk_q;
            node_rd_en   = 1'b1;
            node_rd_addr = stk_q;
         end
         ST_RD_M: begin
            wtmp_in      = rd_weight;
            node_rd_en   = 1'b1;
            node_rd_addr = rd_parent;
         end
         ST_RD_P: begin
            arith_cmd.start = 1'b1;
            arith_cmd.op    = OP_MUL;
            arith_cmd.num   = {{(PROD_W-Q_W){1'b0}}, rd_weight};
            arith_cmd.den   = wtmp_ff;
         end
         ST_CMP_MUL: begin
            if (arith_rsp.done) begin
               node_wr_en     = 1'b1;
               node_wr_addr   = m_ff;
               node_wr_data   = {root_ff, qmul};
            end
         end
         ST_FIND_DONE: begin
            if (!phase_ff) begin
               root_a_in = root_ff;
               phase_in  = 1'b1;
               cur_in    = req_ff.node_b;
               len_in    = '0;
            end else if (root_a_ff == root_ff) begin
               // query reads a first, union reads b first
               node_rd_en   = (req_ff.action == ACT_QUERY);
               node_rd_addr = req_ff.node_a;
            end else begin
               node_rd_en   = (req_ff.action == ACT_UNION);
               node_rd_addr = req_ff.node_b;
            end
         end
         ST_LK_B: begin
            wtmp_in      = rd_weight;
            node_rd_en   = 1'b1;
            node_rd_addr = req_ff.node_a;
         end
         ST_LK_A: begin
            wtmp_in         = rd_weight;
            arith_cmd.start = 1'b1;
            arith_cmd.op    = OP_MUL;
            arith_cmd.num   = {{(PROD_W-Q_W){1'b0}}, req_ff.ratio};
            arith_cmd.den   = wtmp_ff;
         end
         ST_LK_MUL: begin
            arith_cmd.start = arith_rsp.done;
            arith_cmd.op    = OP_DIV;
            arith_cmd.num   = arith_rsp.product;
            arith_cmd.den   = wtmp_ff;
         end
         ST_LK_DIV: begin
            if (arith_rsp.done) begin
               node_wr_en         = 1'b1;
               node_wr_addr       = root_a_ff;
               node_wr_data       = {root_ff, arith_rsp.quotient};
            end
         end
         ST_Q_A: begin
            wtmp_in      = rd_weight;
            node_rd_en   = 1'b1;
            node_rd_addr = req_ff.node_b;
         end
         ST_Q_B: begin
            arith_cmd.start = 1'b1;
            arith_cmd.op    = OP_DIV;
            arith_cmd.num   = {{(PROD_W-Q_W-32){1'b0}}, wtmp_ff, 32'd0};
            arith_cmd.den   = rd_weight;
         end
         ST_Q_DIV: begin
            if (arith_rsp.done) begin
               res_conn_in  = 1'b1;
               res_ratio_in = arith_rsp.quotient;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.connected    = res_conn_ff;
               rsp_data_in.ratio_result = res_ratio_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         b_init_ff    <= 1'b0;
         phase_ff     <= 1'b0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         b_init_ff    <= b_init_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
      end
      req_ff       <= req_in;
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      root_a_ff    <= root_a_in;
      m_ff         <= m_in;
      wtmp_ff      <= wtmp_in;
      res_conn_ff  <= res_conn_in;
      res_ratio_ff <= res_ratio_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a write and a read of the same node entry never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(node_wr_en && node_rd_en && (node_wr_addr == node_rd_addr)))
      else $error("node ram read and write collide");

   // the path stack never holds more than one entry per node
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(NODES))
      else $error("path stack overflow");

   // arithmetic results arrive only where the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> (state_ff == ST_CMP_MUL || state_ff == ST_LK_MUL ||
                          state_ff == ST_LK_DIV || state_ff == ST_Q_DIV))
      else $error("unexpected arithmetic completion");

   // a union transaction marks both nodes seen
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == ACT_UNION) |=>
         (seen_ff[req_ff.node_a] && seen_ff[req_ff.node_b]))
      else $error("union did not mark nodes seen");

   // a connected result is only produced after both nodes were seen
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && res_conn_ff) |->
         (seen_ff[req_ff.node_a] && seen_ff[req_ff.node_b]))
      else $error("connected result for unseen node");

endmodule

FILE: sv/wufr_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module wufr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/wufr_arith.sv
// shared multi-cycle arithmetic: 48x48 product from four 24x24 partials,
// and a restoring divider of a 96-bit dividend, one quotient bit a cycle
// depends on wufr_pkg

module wufr_arith
   import wufr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  arith_cmd_type cmd,
   output arith_rsp_type rsp
);

   localparam int HALF_W = Q_W / 2;
   localparam logic [6:0] MUL_LAST = 7'd4;
   localparam logic [6:0] DIV_LAST = 7'(PROD_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   arith_op_type       op_ff, op_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [PROD_W-1:0]  a_ff, a_in;
   logic [Q_W-1:0]     b_ff, b_in;
   logic [Q_W-1:0]     pp_ff, pp_in;
   logic [1:0]         sh_ff, sh_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [Q_W-1:0]     rem_ff, rem_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic               sat_ff, sat_in;

   logic [HALF_W-1:0]  a_part, b_part;
   logic [PROD_W-1:0]  pp_shifted;
   logic [Q_W:0]       r2;
   logic [Q_W:0]       r2_sub;
   logic               ge;

   always_comb begin
      a_part = cnt_ff[1] ? a_ff[Q_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_part = cnt_ff[0] ? b_ff[Q_W-1:HALF_W] : b_ff[HALF_W-1:0];
      case (sh_ff)
         2'd0:    pp_shifted = {{(PROD_W-Q_W){1'b0}}, pp_ff};
         2'd1:    pp_shifted = {{(PROD_W-Q_W-HALF_W){1'b0}}, pp_ff, {HALF_W{1'b0}}};
         2'd2:    pp_shifted = {pp_ff, {Q_W{1'b0}}};
         default: pp_shifted = '0;
      endcase
      r2     = {rem_ff, a_ff[PROD_W-1]};
      ge     = (r2 >= {1'b0, b_ff});
      r2_sub = r2 - {1'b0, b_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in = 1'b1;
            op_in   = cmd.op;
            cnt_in  = '0;
            a_in    = cmd.num;
            b_in    = cmd.den;
            acc_in  = '0;
            rem_in  = '0;
            q_in    = '0;
            sat_in  = 1'b0;
         end
      end else if (op_ff == OP_MUL) begin
         // multiply two halves into the registered partial, accumulate it in the next
         if (cnt_ff < MUL_LAST) begin
            pp_in = a_part * b_part;
            sh_in = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
         end
         if (cnt_ff != '0) begin
            acc_in = acc_ff + pp_shifted;
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         rem_in = ge ? r2_sub[Q_W-1:0] : r2[Q_W-1:0];
         // quotient too wide for 48 bits
         sat_in = sat_ff | q_ff[Q_W-1];
         q_in   = {q_ff[Q_W-2:0], ge};
         a_in   = {a_ff[PROD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.product  = acc_ff;
   assign rsp.quotient = sat_ff ? Q_MAX : q_ff;

endmodule
